>>> sv/mbi_pkg.sv
// shared types and constants of the bilinear map interpolator
// used by every module of the block but mbi_ram, depends on nothing

package mbi_pkg;

    localparam int LW = 16;  // label and coordinate width
    localparam int DW = 17;  // difference of two labels
    localparam int VW = 36;  // x-step results and their difference
    localparam int PW = 52;  // product and quotient magnitude
    localparam int QW = 54;  // signed step result
    localparam int OW = 24;  // output width
    localparam int CW = 5;   // count register width

    localparam logic [1:0] OP_INTERP    = 2'd0;
    localparam logic [1:0] OP_WR_CELL   = 2'd1;
    localparam logic [1:0] OP_WR_ROW    = 2'd2;
    localparam logic [1:0] OP_WR_COLUMN = 2'd3;

    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]           opcode;
        logic signed [LW-1:0] x_value;
        logic signed [LW-1:0] y_value;
        logic [3:0]           row_select;
        logic [3:0]           column_select;
        logic [7:0]           cell_value;
        logic signed [LW-1:0] label_value;
    } cmd_t;

    typedef struct packed {
        logic signed [OW-1:0] interpolated;
        logic                 saturated;
    } rsp_t;

    typedef enum logic [2:0] {
        SC_IDLE, SC_RD, SC_CK, SC_LO, SC_HI, SC_END
    } scan_state_t;

    typedef enum logic [1:0] {
        MD_IDLE, MD_MUL, MD_DIV, MD_DONE
    } md_state_t;

    typedef enum logic [3:0] {
        T_IDLE, T_SCAN, T_RD0, T_RD1, T_RD2, T_RD3, T_RD4, T_STEP, T_WAIT, T_OUT
    } top_state_t;

endpackage

>>> sv/mbi_ram.sv
// simple dual port synchronous ram, registered read data
// depends on nothing

module mbi_ram #(
    parameter int AW = 4,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/mbi_scan.sv
// breakpoint label store of one axis and its downward bracket search
// depends on mbi_pkg and mbi_ram

module mbi_scan #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic signed [mbi_pkg::LW-1:0] wr_data,
    input  logic                          start,
    input  logic signed [mbi_pkg::LW-1:0] coord,
    input  logic [$clog2(DEPTH)-1:0]      first,
    output logic                          done,
    output logic [$clog2(DEPTH)-1:0]      index,
    output logic signed [mbi_pkg::LW-1:0] lo,
    output logic signed [mbi_pkg::LW-1:0] hi
);

    localparam int AW = $clog2(DEPTH);

    mbi_pkg::scan_state_t state_reg, state_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic signed [mbi_pkg::LW-1:0] lo_reg, lo_next;
    logic [AW-1:0]                raddr;
    logic signed [mbi_pkg::LW-1:0] rdata;

    mbi_ram #(.AW(AW), .DW(mbi_pkg::LW)) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbi_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    state_next = (first == '0) ? mbi_pkg::SC_LO : mbi_pkg::SC_RD;
                end
            end
            mbi_pkg::SC_RD: state_next = mbi_pkg::SC_CK;
            mbi_pkg::SC_CK:
            begin
                if (coord >= rdata || idx_reg == AW'(1))
                begin
                    state_next = mbi_pkg::SC_LO;
                end
                else
                begin
                    state_next = mbi_pkg::SC_RD;
                end
            end
            mbi_pkg::SC_LO:  state_next = mbi_pkg::SC_HI;
            mbi_pkg::SC_HI:  state_next = mbi_pkg::SC_END;
            mbi_pkg::SC_END: state_next = mbi_pkg::SC_IDLE;
            default:         state_next = mbi_pkg::SC_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        lo_next  = lo_reg;
        raddr    = (state_reg == mbi_pkg::SC_HI) ? idx_reg + AW'(1) : idx_reg;
        case (state_reg)
            mbi_pkg::SC_IDLE:
            begin
                if (start)
                begin
                    idx_next = first;
                end
            end
            mbi_pkg::SC_CK:
            begin
                // label below coordinate not found yet: step down
                if (!(coord >= rdata))
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            mbi_pkg::SC_HI:  lo_next = rdata;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbi_pkg::SC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
    end

    // hi is taken straight from the ram in the done cycle
    assign done  = (state_reg == mbi_pkg::SC_END);
    assign index = idx_reg;
    assign lo    = lo_reg;
    assign hi    = rdata;

endmodule

>>> sv/mbi_muldiv.sv
// serial signed multiply then divide: trunc(a * b / d), shift-add then restoring
// depends on mbi_pkg

module mbi_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [mbi_pkg::VW-1:0] mcand,
    input  logic signed [mbi_pkg::DW-1:0] mplier,
    input  logic signed [mbi_pkg::DW-1:0] divisor,
    output logic                          done,
    output logic signed [mbi_pkg::QW-1:0] quot
);

    localparam int PW  = mbi_pkg::PW;
    localparam int DW  = mbi_pkg::DW;
    localparam int NW  = $clog2(PW);

    mbi_pkg::md_state_t state_reg, state_next;
    logic [PW-1:0] acc_reg, acc_next, am_reg, am_next;
    logic [DW-1:0] bm_reg, bm_next, dm_reg, dm_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [DW:0]   rem_sh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbi_pkg::MD_IDLE: if (start) state_next = mbi_pkg::MD_MUL;
            mbi_pkg::MD_MUL:  if (cnt_reg == NW'(DW - 1)) state_next = mbi_pkg::MD_DIV;
            mbi_pkg::MD_DIV:  if (cnt_reg == NW'(PW - 1)) state_next = mbi_pkg::MD_DONE;
            mbi_pkg::MD_DONE: state_next = mbi_pkg::MD_IDLE;
            default:          state_next = mbi_pkg::MD_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        am_next  = am_reg;
        bm_next  = bm_reg;
        dm_next  = dm_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        rem_sh   = {rem_reg, acc_reg[PW-1]};
        case (state_reg)
            mbi_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    am_next  = PW'(mcand[mbi_pkg::VW-1] ? -mcand : mcand);
                    bm_next  = mplier[DW-1] ? -mplier : mplier;
                    dm_next  = divisor[DW-1] ? -divisor : divisor;
                    neg_next = mcand[mbi_pkg::VW-1] ^ mplier[DW-1] ^ divisor[DW-1];
                    acc_next = '0;
                    cnt_next = '0;
                end
            end
            mbi_pkg::MD_MUL:
            begin
                if (bm_reg[0])
                begin
                    acc_next = acc_reg + am_reg;
                end
                am_next  = am_reg << 1;
                bm_next  = bm_reg >> 1;
                rem_next = '0;
                cnt_next = (cnt_reg == NW'(DW - 1)) ? '0 : cnt_reg + NW'(1);
            end
            mbi_pkg::MD_DIV:
            begin
                // one quotient bit per cycle, shifted into the product register
                if (rem_sh >= {1'b0, dm_reg})
                begin
                    rem_next = DW'(rem_sh - {1'b0, dm_reg});
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = DW'(rem_sh);
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + NW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbi_pkg::MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        am_reg  <= am_next;
        bm_reg  <= bm_next;
        dm_reg  <= dm_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign done = (state_reg == mbi_pkg::MD_DONE);
    assign quot = neg_reg ? -$signed(mbi_pkg::QW'(acc_reg)) : $signed(mbi_pkg::QW'(acc_reg));

endmodule

>>> sv/map2d_bilinear_interpolate.sv
// bilinear map interpolator top level: write items are taken in idle, busy stays low
// interpolate item: two label scans in parallel, then cell reads in T_RD0 to T_RD4,
// then three steps on one shared serial multiply/divide unit, where a step between
// equal labels does not use the unit; the done strobe follows the last step
// busy drops with the strobe; results cannot be stalled; rst_n resets control, counts to 2

module map2d_bilinear_interpolate #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  mbi_pkg::cmd_t            cmd,
    output logic                     done,
    output mbi_pkg::rsp_t            result,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [mbi_pkg::CW-1:0]   cfg_data
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLUMNS);
    localparam int VW  = mbi_pkg::VW;
    localparam int QW  = mbi_pkg::QW;
    localparam int DW  = mbi_pkg::DW;
    localparam int LW  = mbi_pkg::LW;
    localparam int OW  = mbi_pkg::OW;
    localparam logic signed [QW-1:0] SAT_HI = QW'({1'b0, {(OW-1){1'b1}}});
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

    mbi_pkg::top_state_t state_reg, state_next;

    logic [mbi_pkg::CW-1:0] row_count_reg, column_count_reg;
    logic [6:0]             nr, nc, rc7, cc7;
    logic [RAW-1:0]         r_first;
    logic [CAW-1:0]         c_first;

    logic accept, interp_go;
    assign accept    = start && !busy;
    assign interp_go = accept && (cmd.opcode == mbi_pkg::OP_INTERP);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= mbi_pkg::CW'(2);
            column_count_reg <= mbi_pkg::CW'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbi_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                mbi_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rc7 = 7'(row_count_reg);
        cc7 = 7'(column_count_reg);
        nr  = (rc7 < 7'd2) ? 7'd2 : (rc7 > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rc7;
        nc  = (cc7 < 7'd2) ? 7'd2 : (cc7 > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : cc7;
    end

    logic [6:0] nr_m2, nc_m2;
    assign nr_m2   = nr - 7'd2;
    assign nc_m2   = nc - 7'd2;
    assign r_first = nr_m2[RAW-1:0];
    assign c_first = nc_m2[CAW-1:0];

    // write decode
    logic       row_ok, col_ok;
    logic [6:0] rs7, cs7;
    assign rs7    = 7'(cmd.row_select);
    assign cs7    = 7'(cmd.column_select);
    assign row_ok = rs7 < 7'(MAX_ROWS);
    assign col_ok = cs7 < 7'(MAX_COLUMNS);

    logic cell_we, row_we, col_we;
    assign cell_we = accept && cmd.opcode == mbi_pkg::OP_WR_CELL && row_ok && col_ok;
    assign row_we  = accept && cmd.opcode == mbi_pkg::OP_WR_ROW && row_ok;
    assign col_we  = accept && cmd.opcode == mbi_pkg::OP_WR_COLUMN && col_ok;

    // latched coordinates
    logic signed [LW-1:0] x_reg, y_reg;
    always_ff @(posedge clk)
    begin
        if (interp_go)
        begin
            x_reg <= cmd.x_value;
            y_reg <= cmd.y_value;
        end
    end

    // label scanners
    logic                 r_done, c_done;
    logic [RAW-1:0]       ri;
    logic [CAW-1:0]       ci;
    logic signed [LW-1:0] r_lo, r_hi, c_lo, c_hi;

    // the scanners compare only in their check state, when the latched copy is valid
    mbi_scan #(.DEPTH(MAX_ROWS)) u_row_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (row_we),
        .wr_addr (rs7[RAW-1:0]),
        .wr_data (cmd.label_value),
        .start   (interp_go),
        .coord   (y_reg),
        .first   (r_first),
        .done    (r_done),
        .index   (ri),
        .lo      (r_lo),
        .hi      (r_hi)
    );

    mbi_scan #(.DEPTH(MAX_COLUMNS)) u_col_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (col_we),
        .wr_addr (cs7[CAW-1:0]),
        .wr_data (cmd.label_value),
        .start   (interp_go),
        .coord   (x_reg),
        .first   (c_first),
        .done    (c_done),
        .index   (ci),
        .lo      (c_lo),
        .hi      (c_hi)
    );

    // hi labels arrive only in the done cycle
    logic signed [LW-1:0] r_hi_reg, c_hi_reg;
    logic                 r_dn_reg, c_dn_reg;

    // cell map
    logic [RAW+CAW-1:0] cell_raddr;
    logic [7:0]         cell_rdata;
    logic [7:0]         c00_reg, c01_reg, c10_reg, c11_reg;

    mbi_ram #(.AW(RAW+CAW), .DW(8)) u_cells (
        .clk   (clk),
        .we    (cell_we),
        .waddr ({rs7[RAW-1:0], cs7[CAW-1:0]}),
        .wdata (cmd.cell_value),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // step unit
    logic [1:0]              step_reg, step_next;
    logic signed [VW-1:0]    a_reg, a_next, b_reg, b_next;
    logic signed [QW-1:0]    c_reg, c_next;
    logic signed [LW-1:0]    v, lo, hi;
    logic signed [VW-1:0]    p, q;
    logic signed [DW-1:0]    span, dv;
    logic                    md_start, md_done;
    logic signed [QW-1:0]    md_quot, step_res;
    logic                    store;
    mbi_pkg::rsp_t           rsp_reg, rsp_next;
    logic                    done_reg, done_next;

    mbi_muldiv u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .mcand   (q - p),
        .mplier  (dv),
        .divisor (span),
        .done    (md_done),
        .quot    (md_quot)
    );

    always_comb
    begin
        v  = (step_reg == 2'd2) ? y_reg : x_reg;
        lo = (step_reg == 2'd2) ? r_lo : c_lo;
        hi = (step_reg == 2'd2) ? r_hi_reg : c_hi_reg;
        case (step_reg)
            2'd0:
            begin
                p = $signed(VW'({c00_reg, 8'h00}));
                q = $signed(VW'({c01_reg, 8'h00}));
            end
            2'd1:
            begin
                p = $signed(VW'({c10_reg, 8'h00}));
                q = $signed(VW'({c11_reg, 8'h00}));
            end
            default:
            begin
                p = a_reg;
                q = b_reg;
            end
        endcase
        span = DW'(hi) - DW'(lo);
        dv   = DW'(v) - DW'(lo);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbi_pkg::T_IDLE: if (interp_go) state_next = mbi_pkg::T_SCAN;
            mbi_pkg::T_SCAN:
            begin
                if ((r_dn_reg || r_done) && (c_dn_reg || c_done))
                begin
                    state_next = mbi_pkg::T_RD0;
                end
            end
            mbi_pkg::T_RD0: state_next = mbi_pkg::T_RD1;
            mbi_pkg::T_RD1: state_next = mbi_pkg::T_RD2;
            mbi_pkg::T_RD2: state_next = mbi_pkg::T_RD3;
            mbi_pkg::T_RD3: state_next = mbi_pkg::T_RD4;
            mbi_pkg::T_RD4: state_next = mbi_pkg::T_STEP;
            mbi_pkg::T_STEP:
            begin
                if (span != '0)
                begin
                    state_next = mbi_pkg::T_WAIT;
                end
                else if (step_reg == 2'd2)
                begin
                    state_next = mbi_pkg::T_OUT;
                end
                else
                begin
                    state_next = mbi_pkg::T_STEP;
                end
            end
            mbi_pkg::T_WAIT:
            begin
                if (md_done)
                begin
                    state_next = (step_reg == 2'd2) ? mbi_pkg::T_OUT : mbi_pkg::T_STEP;
                end
            end
            mbi_pkg::T_OUT: state_next = mbi_pkg::T_IDLE;
            default:        state_next = mbi_pkg::T_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        md_start   = 1'b0;
        store      = 1'b0;
        cell_raddr = {ri, ci};
        // equal neighbouring labels give the raw coordinate in q8
        step_res   = (state_reg == mbi_pkg::T_WAIT) ? QW'(p) + md_quot : QW'(v) <<< 8;
        case (state_reg)
            mbi_pkg::T_RD0: cell_raddr = {ri, ci};
            mbi_pkg::T_RD1: cell_raddr = {ri, ci + CAW'(1)};
            mbi_pkg::T_RD2: cell_raddr = {ri + RAW'(1), ci};
            mbi_pkg::T_RD3: cell_raddr = {ri + RAW'(1), ci + CAW'(1)};
            mbi_pkg::T_RD4: step_next = 2'd0;
            mbi_pkg::T_STEP:
            begin
                if (span != '0)
                begin
                    md_start = 1'b1;
                end
                else
                begin
                    store = 1'b1;
                end
            end
            mbi_pkg::T_WAIT: store = md_done;
            mbi_pkg::T_OUT:
            begin
                done_next = 1'b1;
                if (c_reg > SAT_HI)
                begin
                    rsp_next.interpolated = OW'(SAT_HI);
                    rsp_next.saturated    = 1'b1;
                end
                else if (c_reg < SAT_LO)
                begin
                    rsp_next.interpolated = OW'(SAT_LO);
                    rsp_next.saturated    = 1'b1;
                end
                else
                begin
                    rsp_next.interpolated = OW'(c_reg);
                    rsp_next.saturated    = 1'b0;
                end
            end
            default: ;
        endcase
        if (store)
        begin
            case (step_reg)
                2'd0:    a_next = VW'(step_res);
                2'd1:    b_next = VW'(step_res);
                default: c_next = step_res;
            endcase
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbi_pkg::T_IDLE;
            done_reg  <= 1'b0;
            r_dn_reg  <= 1'b0;
            c_dn_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            r_dn_reg  <= interp_go ? 1'b0 : (r_dn_reg || r_done);
            c_dn_reg  <= interp_go ? 1'b0 : (c_dn_reg || c_done);
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        rsp_reg  <= rsp_next;
        if (r_done)
        begin
            r_hi_reg <= r_hi;
        end
        if (c_done)
        begin
            c_hi_reg <= c_hi;
        end
        case (state_reg)
            mbi_pkg::T_RD1: c00_reg <= cell_rdata;
            mbi_pkg::T_RD2: c01_reg <= cell_rdata;
            mbi_pkg::T_RD3: c10_reg <= cell_rdata;
            mbi_pkg::T_RD4: c11_reg <= cell_rdata;
            default: ;
        endcase
    end

    assign busy   = (state_reg != mbi_pkg::T_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == mbi_pkg::T_OUT))
        else $error("result strobe without a finished item");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |->
            (result.interpolated == OW'(SAT_HI) || result.interpolated == OW'(SAT_LO)))
        else $error("saturated flag with an unclipped value");

    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (r_done || c_done) |-> state_reg == mbi_pkg::T_SCAN)
        else $error("label scan finished outside the scan phase");

    a_md_only_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == mbi_pkg::T_WAIT)
        else $error("divide result arrived while not waiting for it");

endmodule

>>> sim/map2d_bilinear_interpolate_tb.sv
// testbench of map2d_bilinear_interpolate: fill, directed table, random map phases
// keeps its own lookup of cells and labels and predicts each interpolate result
// that the table does not give; depends on mbi_pkg and the block itself

module map2d_bilinear_interpolate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NR = 16;
    localparam int  NC = 16;
    localparam int  SETTLE = 300;
    localparam int  CMD_W = $bits(mbi_pkg::cmd_t);
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        mbi_pkg::cmd_t      c;
        bit                 typed;
        logic signed [23:0] val;
        logic               sat;
    } dir_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    mbi_pkg::cmd_t cmd = '0;
    logic          done;
    mbi_pkg::rsp_t result;
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [mbi_pkg::CW-1:0] cfg_data = '0;

    logic [7:0]         cells [NR][NC];
    logic signed [15:0] row_lab [NR];
    logic signed [15:0] col_lab [NC];
    int unsigned        row_cnt, col_cnt;

    mbi_pkg::rsp_t pending_rsp[$];
    int       errors = 0;
    longint   cycles = 0;
    bit       gaps_on = 1'b1;
    int       items = 0;
    dir_row_t dir_tab[$];

    map2d_bilinear_interpolate #(.MAX_ROWS(NR), .MAX_COLUMNS(NC)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        mbi_pkg::rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report("result with nothing pending");
            else
            begin
                want = pending_rsp.pop_front();
                if (result.interpolated !== want.interpolated)
                    report($sformatf("interpolated %0d, want %0d",
                                     result.interpolated, want.interpolated));
                if (result.saturated !== want.saturated)
                    report($sformatf("saturated %0b, want %0b",
                                     result.saturated, want.saturated));
            end
        end
    end

    function automatic int unsigned eff_count(input int unsigned n, input int unsigned mx);
        if (n < 2) return 2;
        if (n > mx) return mx;
        return n;
    endfunction

    // first of n-2 .. 1 whose label is not above v, else 0
    function automatic int unsigned bracket(input longint v, input bit is_row,
                                            input int unsigned n);
        for (int i = int'(n) - 2; i > 0; i--)
        begin
            if (v >= (is_row ? row_lab[i] : col_lab[i])) return i;
        end
        return 0;
    endfunction

    function automatic longint step_q8(input longint v, input longint lo,
                                       input longint hi, input longint p,
                                       input longint q);
        if (hi == lo) return v * 256;
        return p + ((v - lo) * (q - p)) / (hi - lo);
    endfunction

    function automatic mbi_pkg::rsp_t lookup_q8(input mbi_pkg::cmd_t c);
        mbi_pkg::rsp_t r;
        int unsigned ci, ri;
        longint x, y, a, b, v;
        x = c.x_value;
        y = c.y_value;
        ci = bracket(x, 1'b0, eff_count(col_cnt, NC));
        ri = bracket(y, 1'b1, eff_count(row_cnt, NR));
        a = step_q8(x, col_lab[ci], col_lab[ci+1],
                    longint'(cells[ri][ci]) * 256, longint'(cells[ri][ci+1]) * 256);
        b = step_q8(x, col_lab[ci], col_lab[ci+1],
                    longint'(cells[ri+1][ci]) * 256, longint'(cells[ri+1][ci+1]) * 256);
        v = step_q8(y, row_lab[ri], row_lab[ri+1], a, b);
        r.saturated = 1'b0;
        if (v > 8388607)
        begin
            v = 8388607;
            r.saturated = 1'b1;
        end
        else if (v < -8388608)
        begin
            v = -8388608;
            r.saturated = 1'b1;
        end
        r.interpolated = v[23:0];
        return r;
    endfunction

    // updates the lookup copy and returns 1 when a result is due
    function automatic bit apply_item(input mbi_pkg::cmd_t c);
        case (c.opcode)
            mbi_pkg::OP_WR_CELL:   cells[c.row_select][c.column_select] = c.cell_value;
            mbi_pkg::OP_WR_ROW:    row_lab[c.row_select] = c.label_value;
            mbi_pkg::OP_WR_COLUMN: col_lab[c.column_select] = c.label_value;
            default:               return 1'b1;
        endcase
        return 1'b0;
    endfunction

    task automatic send(input mbi_pkg::cmd_t c, input bit typed = 0,
                        input logic signed [23:0] tval = '0, input logic tsat = 0);
        mbi_pkg::rsp_t r;
        int gap;
        if (gaps_on && $urandom_range(99) < 10)
        begin
            gap = int'($urandom_range(1, 8));
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        items++;
        if (apply_item(c))
        begin
            if (typed)
            begin
                r.interpolated = tval;
                r.saturated = tsat;
            end
            else
                r = lookup_q8(c);
            pending_rsp.push_back(r);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[mbi_pkg::CW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mbi_pkg::CFG_ROW_COUNT) row_cnt = val[mbi_pkg::CW-1:0];
        else col_cnt = val[mbi_pkg::CW-1:0];
    endtask

    function automatic mbi_pkg::cmd_t rand_cmd(input logic [1:0] op);
        mbi_pkg::cmd_t c;
        c = mbi_pkg::cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
        c.opcode = op;
        return c;
    endfunction

    function automatic dir_row_t mk(input logic [1:0] op, input int x, input int y,
                                    input int rs, input int cs, input int cv,
                                    input int lv, input bit typed = 0,
                                    input int val = 0, input bit sat = 0);
        dir_row_t d;
        d.c = rand_cmd(op);
        d.c.x_value = 16'(x);
        d.c.y_value = 16'(y);
        d.c.row_select = 4'(rs);
        d.c.column_select = 4'(cs);
        d.c.cell_value = 8'(cv);
        d.c.label_value = 16'(lv);
        d.typed = typed;
        d.val = 24'(val);
        d.sat = sat;
        return d;
    endfunction

    // ascending labels, mostly; steps of zero give equal neighbours now and then
    task automatic load_labels(input bit is_row, input int unsigned n, input bit wide);
        mbi_pkg::cmd_t c;
        int lab;
        lab = wide ? -32768 : -int'($urandom_range(3000));
        for (int i = 0; i < n; i++)
        begin
            c = rand_cmd(is_row ? mbi_pkg::OP_WR_ROW : mbi_pkg::OP_WR_COLUMN);
            if ($urandom_range(99) < 8) lab = int'($urandom_range(65535)) - 32768;
            else if (wide && i == n - 1) lab = 32767;
            if (lab > 32767) lab = 32767;
            if (is_row) c.row_select = 4'(i);
            else c.column_select = 4'(i);
            c.label_value = 16'(lab);
            send(c);
            lab += wide ? 65535 / int'(n)
                        : ($urandom_range(99) < 10 ? 0 : int'($urandom_range(1, 400)));
        end
    endtask

    function automatic logic signed [15:0] pick_coord(input bit is_row, input int unsigned n);
        int lo, hi, v;
        lo = is_row ? row_lab[0] : col_lab[0];
        hi = is_row ? row_lab[n-1] : col_lab[n-1];
        if (hi < lo) hi = lo;
        if ($urandom_range(99) < 25) return 16'($urandom);
        v = int'($urandom_range(hi - lo + 400)) + lo - 200;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    initial
    begin
        int unsigned nr, nc, phase;
        mbi_pkg::cmd_t c;
        int unsigned count_set[] = '{2, 16, 0, 1, 17, 31, 3, 9};

        row_cnt = 2;
        col_cnt = 2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry written once, so nothing unwritten is ever read
        for (int r = 0; r < NR; r++)
            for (int k = 0; k < NC; k++)
            begin
                c = rand_cmd(mbi_pkg::OP_WR_CELL);
                c.row_select = 4'(r);
                c.column_select = 4'(k);
                send(c);
            end
        for (int i = 0; i < 16; i++)
        begin
            c = rand_cmd(mbi_pkg::OP_WR_ROW);
            c.row_select = 4'(i);
            send(c);
            c = rand_cmd(mbi_pkg::OP_WR_COLUMN);
            c.column_select = 4'(i);
            send(c);
        end

        dir_tab.push_back(mk(mbi_pkg::OP_WR_COLUMN, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_COLUMN, 0, 0, 0, 1, 0, 100));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_ROW, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_ROW, 0, 0, 1, 0, 0, 100));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_CELL, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_CELL, 0, 0, 0, 1, 255, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_CELL, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_CELL, 0, 0, 1, 1, 255, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 100, 0, 0, 0, 0, 0, 1, 65280, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 32767, 0, 0, 0, 0, 0, 1, 8388607, 1));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, -32768, 0, 0, 0, 0, 0, 1, -8388608, 1));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 50, 50, 0, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 37, -32768, 0, 0, 0, 0));
        // equal column labels: the x steps give the raw coordinate
        dir_tab.push_back(mk(mbi_pkg::OP_WR_COLUMN, 0, 0, 0, 1, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 5, 0, 0, 0, 0, 0, 1, 1280, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_WR_ROW, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 3, -32768, 0, 0, 0, 0, 1, -8388608, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 3, 32767, 0, 0, 0, 0, 1, 8388352, 0));
        dir_tab.push_back(mk(mbi_pkg::OP_INTERP, 9, -1, 0, 0, 0, 0, 1, -256, 0));

        foreach (dir_tab[i])
            send(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].val, dir_tab[i].sat);

        // hold off until the block has answered everything
        drain();

        phase = 0;
        while (items < 850)
        begin
            nr = phase < count_set.size() ? count_set[phase] : $urandom_range(2, 16);
            nc = phase < count_set.size() ? count_set[(phase + 3) % count_set.size()]
                                          : $urandom_range(2, 16);
            write_reg(mbi_pkg::CFG_ROW_COUNT, nr);
            write_reg(mbi_pkg::CFG_COLUMN_COUNT, nc);
            nr = eff_count(nr, NR);
            nc = eff_count(nc, NC);
            gaps_on = (phase != 2);
            load_labels(1'b1, nr, phase == 1);
            load_labels(1'b0, nc, phase == 1);
            for (int i = 0; i < 40; i++)
            begin
                case ($urandom_range(9))
                    0, 1:    send(rand_cmd(mbi_pkg::OP_WR_CELL));
                    2:       send(rand_cmd(mbi_pkg::OP_WR_COLUMN));
                    3:       send(rand_cmd(mbi_pkg::OP_WR_ROW));
                    default:
                    begin
                        c = rand_cmd(mbi_pkg::OP_INTERP);
                        c.x_value = pick_coord(1'b0, nc);
                        c.y_value = pick_coord(1'b1, nr);
                        send(c);
                    end
                endcase
            end
            phase++;
        end

        start <= 1'b0;
        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
